FILE: hdl/opvc_pkg.sv
// Shared types and constants of the octilinear polygon vertex capture block.
// Used by opvc_ctrl, opvc_datapath and the top level; depends on nothing.
package opvc_pkg;

	localparam int MAX_POINTS = 128;
	localparam int COORD_BITS = 32;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int VIDX_W     = 7;
	localparam int VCNT_W     = 8;

	localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam logic [CNT_W-1:0] FULL_LEVEL    = CNT_W'(MAX_POINTS - 2);
	localparam logic [CNT_W-1:0] CLOSE_MIN_CNT = CNT_W'(3);

	typedef enum logic [1:0] {
		OP_CLEAR    = 2'd0,
		OP_POINT    = 2'd1,
		OP_READ     = 2'd2,
		OP_READ_ALT = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STS_SAME      = 3'd0,
		STS_FULL      = 3'd1,
		STS_APPENDED  = 3'd2,
		STS_REPLACED  = 3'd3,
		STS_RETRACTED = 3'd4,
		STS_CLEARED   = 3'd5,
		STS_READ      = 3'd6,
		STS_CLOSED    = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_APPEND_RAW,
		ACT_APPEND,
		ACT_REPLACE,
		ACT_RETRACT,
		ACT_CLEAR,
		ACT_READ
	} act_t;

	// Direction class of a segment.
	typedef enum logic [1:0] {
		CLS_HORZ,
		CLS_DIAG_POS,
		CLS_VERT,
		CLS_DIAG_NEG
	} cls_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DIFF,
		ST_SNAP,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic    load;
		logic    rd;
		logic    diff;
		logic    snap;
		logic    commit;
		act_t    act;
		status_t status;
	} dp_cmd_t;

	typedef struct packed {
		logic op_clear;
		logic op_read;
		logic closed;
		logic cnt_zero;
		logic cnt_one;
		logic full;
		logic same_point;
		logic class_eq;
		logic on_prev;
	} dp_flags_t;

endpackage

FILE: hdl/opvc_ctrl.sv
// Controller of the vertex capture block: sequences each transfer and picks the outcome.
// Depends on opvc_pkg for the state, command and flag types.
module opvc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  opvc_pkg::dp_flags_t flags,
	output opvc_pkg::dp_cmd_t   cmd
);

	opvc_pkg::state_t state_q;
	opvc_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= opvc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			opvc_pkg::ST_IDLE: begin
				if (start) begin
					state_d = opvc_pkg::ST_READ;
				end
			end
			opvc_pkg::ST_READ: begin
				if (flags.op_clear || flags.op_read) begin
					state_d = opvc_pkg::ST_COMMIT;
				end else begin
					state_d = opvc_pkg::ST_DIFF;
				end
			end
			opvc_pkg::ST_DIFF:   state_d = opvc_pkg::ST_SNAP;
			opvc_pkg::ST_SNAP:   state_d = opvc_pkg::ST_COMMIT;
			opvc_pkg::ST_COMMIT: state_d = opvc_pkg::ST_IDLE;
			default:             state_d = opvc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.act    = opvc_pkg::ACT_NONE;
		cmd.status = opvc_pkg::STS_SAME;
		busy       = 1'b1;
		case (state_q)
			opvc_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			opvc_pkg::ST_READ: cmd.rd   = 1'b1;
			opvc_pkg::ST_DIFF: cmd.diff = 1'b1;
			opvc_pkg::ST_SNAP: cmd.snap = 1'b1;
			opvc_pkg::ST_COMMIT: begin
				cmd.commit = 1'b1;
				// The order of these tests is the priority of the outcomes.
				if (flags.op_clear) begin
					cmd.act    = opvc_pkg::ACT_CLEAR;
					cmd.status = opvc_pkg::STS_CLEARED;
				end else if (flags.op_read) begin
					cmd.act    = opvc_pkg::ACT_READ;
					cmd.status = opvc_pkg::STS_READ;
				end else if (flags.closed) begin
					cmd.status = opvc_pkg::STS_CLOSED;
				end else if (flags.cnt_zero) begin
					cmd.act    = opvc_pkg::ACT_APPEND_RAW;
					cmd.status = opvc_pkg::STS_APPENDED;
				end else if (flags.same_point) begin
					cmd.status = opvc_pkg::STS_SAME;
				end else if (flags.full) begin
					cmd.status = opvc_pkg::STS_FULL;
				end else if (flags.cnt_one || !flags.class_eq) begin
					cmd.act    = opvc_pkg::ACT_APPEND;
					cmd.status = opvc_pkg::STS_APPENDED;
				end else if (flags.on_prev) begin
					cmd.act    = opvc_pkg::ACT_RETRACT;
					cmd.status = opvc_pkg::STS_RETRACTED;
				end else begin
					cmd.act    = opvc_pkg::ACT_REPLACE;
					cmd.status = opvc_pkg::STS_REPLACED;
				end
			end
			default: busy = 1'b1;
		endcase
	end

	a_commit_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> ($past(state_q) == opvc_pkg::ST_SNAP ||
			$past(state_q) == opvc_pkg::ST_READ))
		else $error("commit without a preceding read or snap step");

	a_load_returns_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> busy)
		else $error("block not busy after a transfer was taken");

	a_offer_takes_diff: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == opvc_pkg::ST_READ && !flags.op_clear && !flags.op_read) |=>
			state_q == opvc_pkg::ST_DIFF)
		else $error("point offer skipped the difference step");

endmodule

FILE: hdl/opvc_datapath.sv
// Datapath of the vertex capture block: vertex stores, snap arithmetic, count and closed flag.
// Depends on opvc_pkg; driven by opvc_ctrl through dp_cmd_t and reports through dp_flags_t.
module opvc_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  opvc_pkg::dp_cmd_t                   cmd,
	output opvc_pkg::dp_flags_t                 flags,
	input  logic [1:0]                          operation,
	input  logic [opvc_pkg::COORD_BITS-1:0]     point_x,
	input  logic [opvc_pkg::COORD_BITS-1:0]     point_y,
	input  logic [opvc_pkg::VIDX_W-1:0]         vertex_index,
	output logic                                done,
	output logic [2:0]                          status,
	output logic [opvc_pkg::COORD_BITS-1:0]     out_x,
	output logic [opvc_pkg::COORD_BITS-1:0]     out_y,
	output logic [opvc_pkg::VCNT_W-1:0]         vertex_count,
	output logic                                is_closed
);

	localparam int N = opvc_pkg::COORD_BITS;

	logic [N-1:0] mem_x [opvc_pkg::MAX_POINTS];
	logic [N-1:0] mem_y [opvc_pkg::MAX_POINTS];

	opvc_pkg::op_t                 op_q;
	logic [N-1:0]                  px_q, py_q;
	logic [opvc_pkg::VIDX_W-1:0]   idx_q;
	logic [N-1:0]                  first_x_q, first_y_q;
	logic [opvc_pkg::CNT_W-1:0]    count_q;
	logic                          closed_q;
	logic                          done_q;
	opvc_pkg::status_t             status_q;
	logic [N-1:0]                  out_x_q, out_y_q;

	// Last vertex (port a, or the read entry) and the one before it (port b).
	logic [N-1:0] la_x_s1, la_y_s1, lb_x_s1, lb_y_s1;
	logic [N-1:0] dx_s2, dy_s2, ax_s2, ay_s2, pdx_s2, pdy_s2;
	logic [N-1:0] nx_s3, ny_s3;
	opvc_pkg::cls_t new_cls_s3, prev_cls_s3;

	logic                       is_read, is_clear, idx_ok;
	logic [opvc_pkg::IDX_W-1:0] addr_a, addr_b, wr_addr;
	logic [opvc_pkg::CNT_W-1:0] cnt_m1, cnt_next;
	logic [N-1:0]               dx, dy, pdx, pdy;
	logic                       vert, horiz;
	logic [N-1:0]               sdx, sdy;
	opvc_pkg::cls_t             new_cls, prev_cls;
	logic                       wr_en;
	logic [N-1:0]               wr_x, wr_y;

	always_comb begin
		is_clear = (op_q == opvc_pkg::OP_CLEAR);
		is_read  = (op_q == opvc_pkg::OP_READ || op_q == opvc_pkg::OP_READ_ALT);
		idx_ok   = (32'(idx_q) < 32'(opvc_pkg::MAX_POINTS));
		cnt_m1   = count_q - opvc_pkg::CNT_W'(1);
		addr_a   = is_read ? opvc_pkg::IDX_W'(idx_q) : cnt_m1[opvc_pkg::IDX_W-1:0];
		addr_b   = opvc_pkg::IDX_W'(count_q - opvc_pkg::CNT_W'(2));
	end

	// Difference step: offset from the last vertex and the previous segment.
	always_comb begin
		dx  = px_q - la_x_s1;
		dy  = py_q - la_y_s1;
		pdx = la_x_s1 - lb_x_s1;
		pdy = la_y_s1 - lb_y_s1;
	end

	// Snap step: pick horizontal, vertical or diagonal by magnitude.
	always_comb begin
		vert  = {1'b0, ay_s2} > {ax_s2, 1'b0};
		horiz = {1'b0, ax_s2} > {ay_s2, 1'b0};
		if (vert) begin
			sdx     = '0;
			sdy     = dy_s2;
			new_cls = opvc_pkg::CLS_VERT;
		end else if (horiz) begin
			sdx     = dx_s2;
			sdy     = '0;
			new_cls = opvc_pkg::CLS_HORZ;
		end else begin
			sdx     = dx_s2[N-1] ? -ay_s2 : ay_s2;
			sdy     = dy_s2;
			new_cls = (dx_s2[N-1] == dy_s2[N-1]) ? opvc_pkg::CLS_DIAG_POS
				: opvc_pkg::CLS_DIAG_NEG;
		end
		// An opposite step needs the negation to be exact, which the most
		// negative value is not.
		if ((pdx_s2 + pdy_s2) == '0 && pdx_s2 != opvc_pkg::COORD_MIN) begin
			prev_cls = opvc_pkg::CLS_DIAG_NEG;
		end else if (pdy_s2 == pdx_s2) begin
			prev_cls = opvc_pkg::CLS_DIAG_POS;
		end else if (pdx_s2 == '0) begin
			prev_cls = opvc_pkg::CLS_VERT;
		end else begin
			prev_cls = opvc_pkg::CLS_HORZ;
		end
	end

	always_comb begin
		flags.op_clear   = is_clear;
		flags.op_read    = is_read;
		flags.closed     = closed_q;
		flags.cnt_zero   = (count_q == '0);
		flags.cnt_one    = (count_q == opvc_pkg::CNT_W'(1));
		flags.full       = (count_q >= opvc_pkg::FULL_LEVEL);
		flags.same_point = (dx_s2 == '0) && (dy_s2 == '0);
		flags.class_eq   = (new_cls_s3 == prev_cls_s3);
		flags.on_prev    = (nx_s3 == lb_x_s1) && (ny_s3 == lb_y_s1);
	end

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = cnt_m1[opvc_pkg::IDX_W-1:0];
		wr_x     = nx_s3;
		wr_y     = ny_s3;
		cnt_next = count_q;
		case (cmd.act)
			opvc_pkg::ACT_APPEND_RAW: begin
				wr_en    = 1'b1;
				wr_addr  = count_q[opvc_pkg::IDX_W-1:0];
				wr_x     = px_q;
				wr_y     = py_q;
				cnt_next = count_q + opvc_pkg::CNT_W'(1);
			end
			opvc_pkg::ACT_APPEND: begin
				wr_en    = 1'b1;
				wr_addr  = count_q[opvc_pkg::IDX_W-1:0];
				cnt_next = count_q + opvc_pkg::CNT_W'(1);
			end
			opvc_pkg::ACT_REPLACE: wr_en = 1'b1;
			opvc_pkg::ACT_RETRACT: begin
				wr_en    = 1'b1;
				cnt_next = cnt_m1;
			end
			opvc_pkg::ACT_CLEAR: cnt_next = '0;
			default: cnt_next = count_q;
		endcase
		wr_en = wr_en && cmd.commit;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			la_x_s1 <= mem_x[addr_a];
			la_y_s1 <= mem_y[addr_a];
			lb_x_s1 <= mem_x[addr_b];
			lb_y_s1 <= mem_y[addr_b];
		end
		if (wr_en) begin
			mem_x[wr_addr] <= wr_x;
			mem_y[wr_addr] <= wr_y;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opvc_pkg::op_t'(operation);
			px_q  <= point_x;
			py_q  <= point_y;
			idx_q <= vertex_index;
		end
		if (cmd.diff) begin
			dx_s2  <= dx;
			dy_s2  <= dy;
			ax_s2  <= dx[N-1] ? -dx : dx;
			ay_s2  <= dy[N-1] ? -dy : dy;
			pdx_s2 <= pdx;
			pdy_s2 <= pdy;
		end
		if (cmd.snap) begin
			nx_s3       <= la_x_s1 + sdx;
			ny_s3       <= la_y_s1 + sdy;
			new_cls_s3  <= new_cls;
			prev_cls_s3 <= prev_cls;
		end
		if (cmd.commit) begin
			status_q <= cmd.status;
			case (cmd.act)
				opvc_pkg::ACT_CLEAR: begin
					out_x_q <= '0;
					out_y_q <= '0;
				end
				opvc_pkg::ACT_READ: begin
					out_x_q <= idx_ok ? la_x_s1 : '0;
					out_y_q <= idx_ok ? la_y_s1 : '0;
				end
				opvc_pkg::ACT_APPEND, opvc_pkg::ACT_REPLACE, opvc_pkg::ACT_RETRACT: begin
					out_x_q <= nx_s3;
					out_y_q <= ny_s3;
				end
				default: begin
					out_x_q <= px_q;
					out_y_q <= py_q;
				end
			endcase
			if (cmd.act == opvc_pkg::ACT_APPEND_RAW) begin
				first_x_q <= px_q;
				first_y_q <= py_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			closed_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= cmd.commit;
			if (cmd.commit) begin
				count_q <= cnt_next;
				if (cmd.act == opvc_pkg::ACT_CLEAR) begin
					closed_q <= 1'b0;
				end else if ((cmd.act == opvc_pkg::ACT_APPEND ||
					cmd.act == opvc_pkg::ACT_REPLACE ||
					cmd.act == opvc_pkg::ACT_RETRACT) &&
					cnt_next > opvc_pkg::CLOSE_MIN_CNT &&
					nx_s3 == first_x_q && ny_s3 == first_y_q) begin
					closed_q <= 1'b1;
				end
			end
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign out_x        = out_x_q;
	assign out_y        = out_y_q;
	assign vertex_count = opvc_pkg::VCNT_W'(count_q);
	assign is_closed    = closed_q;

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= opvc_pkg::FULL_LEVEL)
		else $error("vertex count beyond the store limit");

	a_closed_needs_vertices: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q |-> (count_q > opvc_pkg::CLOSE_MIN_CNT))
		else $error("closed flag with too few vertices");

	a_retract_drops_one: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && cmd.act == opvc_pkg::ACT_RETRACT) |=>
			(count_q == $past(count_q) - opvc_pkg::CNT_W'(1)))
		else $error("retraction did not remove exactly one vertex");

	a_done_single_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");

endmodule

FILE: hdl/octilinear_polygon_vertex_capture_top.sv
// Top level of the octilinear polygon vertex capture block.
// Depends on opvc_pkg and instantiates opvc_ctrl and opvc_datapath.
//
// Usage: a command transfer is taken at a rising edge where start is high
// and busy is low; operation selects clearing the polygon, offering a point
// (point_x, point_y) or reading a stored vertex (vertex_index). Every command
// produces exactly one result, shown on status, out_x, out_y, vertex_count and
// is_closed for a single cycle while done is high. The receiver cannot stall,
// so the result must be captured in that cycle.
//
// Sequencing: a point offer walks through a store read, a difference step,
// a snap step and a commit step. The next command can be taken in the cycle
// where done is high, so a new command is not taken before the last one is
// through. A clear or a vertex read skips the two arithmetic steps. The
// vertex store has two read ports and one write port, and each command has
// a single commit step.
//
// Reset: arst_n clears the sequencer, the vertex count and the closed flag at
// once. The vertex store itself is not cleared; entries that were never
// written read back as unknown values.
module octilinear_polygon_vertex_capture_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [1:0]                             operation,
	input  logic signed [opvc_pkg::COORD_BITS-1:0] point_x,
	input  logic signed [opvc_pkg::COORD_BITS-1:0] point_y,
	input  logic [opvc_pkg::VIDX_W-1:0]            vertex_index,
	output logic                                   done,
	output logic [2:0]                             status,
	output logic signed [opvc_pkg::COORD_BITS-1:0] out_x,
	output logic signed [opvc_pkg::COORD_BITS-1:0] out_y,
	output logic [opvc_pkg::VCNT_W-1:0]            vertex_count,
	output logic                                   is_closed
);

	// Command and status bundles between the sequencer and the datapath.
	opvc_pkg::dp_cmd_t   cmd;
	opvc_pkg::dp_flags_t flags;

	opvc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.flags  (flags),
		.cmd    (cmd)
	);

	// The datapath holds the store, the snap arithmetic and the result registers.
	opvc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.flags        (flags),
		.operation    (operation),
		.point_x      (point_x),
		.point_y      (point_y),
		.vertex_index (vertex_index),
		.done         (done),
		.status       (status),
		.out_x        (out_x),
		.out_y        (out_y),
		.vertex_count (vertex_count),
		.is_closed    (is_closed)
	);

endmodule
